// File: rtl/assert_macros.svh
// assertion macros shared by hcbp_queue and hcbp_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/hcbp_pkg.sv
// types and constants of the huffman code bit packer
// no dependencies
package hcbp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int SYMBOL_COUNT  = 256;

  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int SYM_W     = 8;
  localparam int LEN_LIMIT = (MAX_CODE_BITS > CODE_W) ? CODE_W : MAX_CODE_BITS;
  localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam int IN_DATA_W = 48;
  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;

  localparam int ACC_W = CODE_W + BYTE_W - 1;
  localparam int TOT_W = $clog2(ACC_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_slot_t;

endpackage

// File: rtl/huffman_code_bit_packer_top.sv
// huffman code bit packer: code table, job queue and MSB-first byte packer
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back
//
// input stream s_*: one transaction per item; s_tuser selects load, encode or
// flush. a load writes a code and its length into the 256-entry table, an
// encode appends the symbol's code to the bit accumulator, a flush sends the
// partial byte zero-padded and empties the accumulator.
// output stream m_*: one transaction per packed byte, first code bit in bit 7;
// m_tlast marks the final byte caused by one input item.
// an encode's first byte passes the lookup register, queue, accumulator and
// output register before it shows on m_tvalid. throughput: one item and one
// byte per cycle while the queue has room and m_tready is high; an item that
// yields n bytes holds the packer while they leave by the single byte lane
// out of the accumulator. the four-entry queue absorbs the difference.
// reset clears the accumulator, queue and handshake state; table entries stay
// undefined until loaded. when m_tvalid is high and m_tready low the output
// register holds, the packer stops, the queue fills and then s_tready drops.
module huffman_code_bit_packer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // symbol[7:0], code_value[39:8], code_length[45:40], zero pad [47:46]
  input  logic [hcbp_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [hcbp_pkg::FUNC_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // packed_byte[7:0]
  output logic [hcbp_pkg::BYTE_W-1:0]     m_tdata,
  output logic                            m_tlast
);

  hcbp_pkg::q_slot_t           push;
  hcbp_pkg::q_slot_t           head;
  logic                        pop;
  logic [hcbp_pkg::QCNT_W-1:0] q_count;

  hcbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .push     (push)
  );

  hcbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/hcbp_front.sv
// front end: input handshake, code table writes and lookups, job issue
// depends on hcbp_pkg
module hcbp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // symbol[7:0], code_value[39:8], code_length[45:40], zero pad [47:46]
  input  logic [hcbp_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [hcbp_pkg::FUNC_W-1:0]     s_tuser,
  input  logic [hcbp_pkg::QCNT_W-1:0]     q_count,
  output hcbp_pkg::q_slot_t               push
);

  localparam int ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

  logic [ENTRY_W-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
  logic [ENTRY_W-1:0] rd_entry;
  logic               s1_valid;
  logic               s1_flush;

  logic                          accept;
  logic [hcbp_pkg::SYM_W-1:0]    symbol;
  logic [hcbp_pkg::CODE_W-1:0]   code_value;
  logic [hcbp_pkg::LEN_W-1:0]    code_length;
  logic [hcbp_pkg::LEN_W-1:0]    len_sat;
  logic [hcbp_pkg::CODE_W-1:0]   bits_masked;
  logic [hcbp_pkg::SYM_IDX_W-1:0] idx;
  logic                          in_range;
  logic                          is_load;
  logic                          is_encode;
  logic                          is_flush;

  assign symbol      = s_tdata[7:0];
  assign code_value  = s_tdata[39:8];
  assign code_length = s_tdata[45:40];
  assign idx         = symbol[hcbp_pkg::SYM_IDX_W-1:0];
  assign in_range    = {1'b0, symbol} < 9'(hcbp_pkg::SYMBOL_COUNT);

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    unique case (s_tuser)
      hcbp_pkg::FUNC_LOAD:   is_load   = 1'b1;
      hcbp_pkg::FUNC_ENCODE: is_encode = 1'b1;
      hcbp_pkg::FUNC_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign len_sat = (code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT)) ?
                   hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT) : code_length;
  assign bits_masked = code_value & ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);

  // one slot is held back for the job in the lookup register
  assign s_tready = hcbp_pkg::QCNT_W'(q_count + hcbp_pkg::QCNT_W'(s1_valid))
                    < hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept && is_load && in_range) begin
      code_mem[idx] <= {len_sat, bits_masked};
    end
    if (accept && is_encode) begin
      rd_entry <= code_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else begin
      s1_valid <= accept && ((is_encode && in_range) || is_flush);
      s1_flush <= is_flush;
    end
  end

  assign push.valid     = s1_valid;
  assign push.job.flush = s1_flush;
  assign push.job.len   = s1_flush ? '0 : rd_entry[ENTRY_W-1 -: hcbp_pkg::LEN_W];
  assign push.job.bits  = rd_entry[hcbp_pkg::CODE_W-1:0];

endmodule

// File: rtl/hcbp_queue.sv
// short job queue between front end and packer
// depends on hcbp_pkg and assert_macros.svh
`include "assert_macros.svh"

module hcbp_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  hcbp_pkg::q_slot_t           push,
  input  logic                        pop,
  output hcbp_pkg::q_slot_t           head,
  output logic [hcbp_pkg::QCNT_W-1:0] count
);

  hcbp_pkg::job_t              slots [hcbp_pkg::QUEUE_DEPTH];
  logic [hcbp_pkg::QPTR_W-1:0] wr_ptr;
  logic [hcbp_pkg::QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= hcbp_pkg::QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= hcbp_pkg::QPTR_W'(rd_ptr + 1'b1);
      end
      count <= hcbp_pkg::QCNT_W'(count + hcbp_pkg::QCNT_W'(push.valid)
                                 - hcbp_pkg::QCNT_W'(pop));
    end
  end

  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];

  `ASSERT_NEVER(a_no_overflow, clk, rst,
                push.valid && !pop && (count == hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH)))
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && (count == '0))

endmodule

// File: rtl/hcbp_back.sv
// back end: bit accumulator and byte output register
// depends on hcbp_pkg and assert_macros.svh
`include "assert_macros.svh"

module hcbp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hcbp_pkg::q_slot_t           head,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // packed_byte[7:0]
  output logic [hcbp_pkg::BYTE_W-1:0] m_tdata,
  output logic                        m_tlast
);

  logic [hcbp_pkg::ACC_W-1:0] acc;
  logic [hcbp_pkg::TOT_W-1:0] total;

  logic                        out_free;
  logic                        emit;
  logic [hcbp_pkg::TOT_W-1:0]  total_after;
  logic                        pop_enc;
  logic                        pop_flush;
  logic [hcbp_pkg::BYTE_W-1:0] enc_byte;
  logic [hcbp_pkg::BYTE_W-1:0] flush_byte;
  logic                        flush_emit;
  logic [3:0]                  flush_shift;

  localparam logic [hcbp_pkg::TOT_W-1:0] BYTE_TOT = hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);

  assign out_free    = !m_tvalid || m_tready;
  assign emit        = total >= BYTE_TOT;
  assign total_after = emit ? hcbp_pkg::TOT_W'(total - BYTE_TOT) : total;
  assign enc_byte    = hcbp_pkg::BYTE_W'(acc >> (total - BYTE_TOT));

  // pending bits move to the top of the byte, low bits padded with zeros
  assign flush_shift = 4'(hcbp_pkg::BYTE_W) - {1'b0, total[2:0]};
  assign flush_byte  = hcbp_pkg::BYTE_W'({8'b0, acc[7:0]} << flush_shift);
  assign flush_emit  = total != '0;

  assign pop_enc   = head.valid && !head.job.flush && (total_after < BYTE_TOT);
  assign pop_flush = head.valid && head.job.flush && !emit;
  assign pop       = out_free && (pop_enc || pop_flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      total <= '0;
    end else if (out_free) begin
      if (pop_enc) begin
        acc   <= (hcbp_pkg::ACC_W'(acc[6:0]) << head.job.len)
                 | hcbp_pkg::ACC_W'(head.job.bits);
        total <= hcbp_pkg::TOT_W'(total_after + hcbp_pkg::TOT_W'(head.job.len));
      end else if (pop_flush) begin
        total <= '0;
      end else if (emit) begin
        total <= total_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit || (pop_flush && flush_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (emit) begin
        m_tdata <= enc_byte;
        m_tlast <= total_after < BYTE_TOT;
      end else begin
        m_tdata <= flush_byte;
        m_tlast <= 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_total_bound, clk, rst, total > hcbp_pkg::TOT_W'(hcbp_pkg::ACC_W))
  `ASSERT_NEXT(a_run_continues, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

// File: dv/tb_huffman_code_bit_packer_top.sv
// testbench for huffman_code_bit_packer_top: table loads, encodes and flushes
// with random idling and a long output stall, checked against a packer model
// depends on hcbp_pkg and huffman_code_bit_packer_top
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_top;
  import hcbp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  class packer_scoreboard;
    logic [CODE_W-1:0] code_bits [SYMBOL_COUNT];
    logic [LEN_W-1:0]  code_len [SYMBOL_COUNT];
    logic [6:0]        pend_bits;
    logic [2:0]        pend_cnt;
    packed_byte_t      bytes_due[$];
    int                errors;

    function new();
      pend_bits = '0;
      pend_cnt = '0;
      errors = 0;
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction

    task report_mismatch(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      $display("%0t: %s got %02h expected %02h", $realtime, what, got, want);
      errors++;
    endtask

    // predicts the bytes caused by one accepted input transaction
    function void absorb_item(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] sym,
                              logic [CODE_W-1:0] val, logic [LEN_W-1:0] len);
      logic [63:0]   acc;
      int unsigned   n_len;
      int unsigned   total;
      int unsigned   n_bytes;
      packed_byte_t  pb;
      if (f == FUNC_LOAD) begin
        n_len = (32'(len) > 32'(LEN_LIMIT)) ? 32'(LEN_LIMIT) : 32'(len);
        code_len[sym] = LEN_W'(n_len);
        code_bits[sym] = CODE_W'(64'(val) & ((64'd1 << n_len) - 64'd1));
      end else if (f == FUNC_ENCODE) begin
        n_len = 32'(code_len[sym]);
        acc = ({57'd0, pend_bits} << n_len) | {32'd0, code_bits[sym]};
        total = 32'(pend_cnt) + n_len;
        n_bytes = total / 8;
        for (int i = 0; i < n_bytes; i++) begin
          total -= 8;
          pb.data = BYTE_W'(acc >> total);
          pb.last = (i == n_bytes - 1);
          bytes_due.push_back(pb);
        end
        pend_cnt = 3'(total);
        pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
      end else if (f == FUNC_FLUSH) begin
        if (pend_cnt != 0) begin
          pb.data = {1'b0, pend_bits} << (8 - pend_cnt);
          pb.last = 1'b1;
          bytes_due.push_back(pb);
        end
        pend_bits = '0;
        pend_cnt = '0;
      end
    endfunction

    task check_byte(logic [BYTE_W-1:0] data, logic last);
      packed_byte_t want;
      if (bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", data, 8'h00);
      end else begin
        want = bytes_due.pop_front();
        if (data !== want.data) report_mismatch("packed byte", data, want.data);
        if (last !== want.last) report_mismatch("tlast", {7'd0, last}, {7'd0, want.last});
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [FUNC_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [BYTE_W-1:0]     m_tdata;
  logic                  m_tlast;

  packer_scoreboard sb;
  logic             loaded [SYMBOL_COUNT];
  int               loaded_syms[$];
  int               in_count;
  int               quiet;
  bit               calm;
  bit               held;

  huffman_code_bit_packer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] sym,
                           logic [CODE_W-1:0] val, logic [LEN_W-1:0] len);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = f;
    s_tdata = {2'b00, len, val, sym};
    do @(posedge clk); while (!s_tready);
    sb.absorb_item(f, sym, val, len);
    in_count++;
    if (f == FUNC_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(int'(sym));
    end
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_item(FUNC_LOAD, 8'd0, 32'h0000_0000, 6'd0);
    send_item(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    send_item(FUNC_LOAD, 8'd1, 32'hA5A5_A5A5, 6'd63);
    send_item(FUNC_LOAD, 8'd2, 32'h0000_0005, 6'd3);
    send_item(FUNC_LOAD, 8'd3, 32'hFFFF_FFFF, 6'd7);
    send_item(FUNC_LOAD, 8'd4, 32'h0000_0001, 6'd1);
    send_item(FUNC_LOAD, 8'd5, 32'h0000_00C3, 6'd8);
    send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
    send_item(FUNC_ENCODE, 8'd2, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd255, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd1, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd3, 32'd0, 6'd0);
    send_item(FUNC_UNUSED, 8'd4, $urandom, 6'd12);
    send_item(FUNC_FLUSH, 8'd255, 32'd0, 6'd0);
    send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd4, 32'd0, 6'd0);
    send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd5, 32'd0, 6'd0);
    send_item(FUNC_LOAD, 8'd4, $urandom, 6'd40);
    send_item(FUNC_ENCODE, 8'd4, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd3, 32'd0, 6'd0);
    send_item(FUNC_ENCODE, 8'd255, 32'd0, 6'd0);
    send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
  endtask

  task automatic run_random();
    int               n;
    int               r;
    logic [LEN_W-1:0] len;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= 180 && n < 240);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = LEN_W'($urandom_range(1, 12));
        else if (r < 90) len = LEN_W'($urandom_range(0, 32));
        else len = LEN_W'($urandom_range(33, 63));
        send_item(FUNC_LOAD, SYM_W'($urandom_range(0, 255)), $urandom, len);
        n++;
      end else if (r < 85) begin
        send_item(FUNC_ENCODE, SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]),
                  $urandom, LEN_W'($urandom_range(0, 63)));
        n++;
      end else if (r < 95) begin
        send_item(FUNC_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
                  LEN_W'($urandom_range(0, 63)));
        n++;
      end else begin
        send_item(FUNC_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
                  LEN_W'($urandom_range(0, 63)));
      end
    end
    calm = 1'b0;
  endtask

  // output side: random stalls, one long hold-off while input keeps coming
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && in_count >= 120) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready = calm || ($urandom_range(0, 99) >= 28);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    for (int i = 0; i < SYMBOL_COUNT; i++) loaded[i] = 1'b0;
    in_count = 0;
    calm = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
